@@ rtl/lfsb_pkg.sv @@
`default_nettype none
package lfsb_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_POP
  } lfsb_state_t;

  typedef enum logic [1:0] {
    CMD_PUSH      = 2'd0,
    CMD_POP_RIGHT = 2'd1,
    CMD_POP_AT    = 2'd2,
    CMD_NONE      = 2'd3
  } lfsb_cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2,
    STS_RSVD  = 2'd3
  } lfsb_status_t;

  // Register index is taken from paddr[2]; only one register exists.
  localparam logic REG_PLATES_PER_STACK = 1'b0;
  localparam logic [4:0] PLATES_RESET = 5'd16;

endpackage
`default_nettype wire

@@ rtl/leftmost_fill_stack_bank.sv @@
// Channel   | Direction | Handshake          | Payload
// command   | in        | start, busy        | in_command, in_push_value, in_stack_index
// result    | out       | out_valid (1 clk)  | out_status, out_popped_value, out_used_stack
// config    | in/out    | psel, penable, ... | paddr, pwdata, prdata
//
// A push holds busy while it scans: the fill counts sit in a single-port-read memory and
// one stack is examined per cycle, from stack 0 upwards. A rightmost pop scans downwards
// from the last stack to the first filled one, then reads the plate memory in ST_POP; a
// pop at a named stack does so too, unless that stack is empty. Each result shows for one
// cycle, the first one with busy low; a no-op or a pop at an absent stack is answered
// from idle. After reset a clearing pass zeroes the fill counts with busy high;
// configuration writes are taken throughout. The receiver cannot stall a result.
`default_nettype none
module leftmost_fill_stack_bank
  import lfsb_pkg::*;
#(
  parameter int NUM_STACKS  = 16,
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_push_value,
  input  wire logic [3:0]  in_stack_index,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [15:0]      out_popped_value,
  output logic [3:0]       out_used_stack,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SW = $clog2(NUM_STACKS);
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int CW = (FW > 5) ? FW : 5;
  localparam int AW = $clog2(NUM_STACKS * STACK_DEPTH);
  localparam logic [SW-1:0] LAST_STACK = SW'(NUM_STACKS - 1);
  localparam logic [CW-1:0] DEPTH_CW   = CW'(STACK_DEPTH);
  localparam logic [AW-1:0] DEPTH_AW   = AW'(STACK_DEPTH);

  lfsb_state_t      state_r, state_nxt;
  lfsb_cmd_t        cmd_r;
  logic [15:0]      val_r;
  logic [3:0]       idx_r;
  logic [SW-1:0]    ptr_r, ptr_nxt;
  logic [4:0]       cap_r;

  logic             out_valid_r;
  lfsb_status_t     out_status_r;
  logic [15:0]      out_pop_r;
  logic [3:0]       out_used_r;

  // Result loading and memory controls from the sequencer.
  logic             res_load;
  lfsb_status_t     res_status;
  logic [15:0]      res_pop;
  logic [3:0]       res_used;
  logic             fill_we;
  logic [FW-1:0]    fill_wdata;
  logic             plate_we;
  logic             plate_re;
  logic [AW-1:0]    plate_addr;

  logic [FW-1:0]    fill_rd;
  logic [VALUE_BITS-1:0] plate_rd;

  logic             accept;
  logic             cfg_write;
  logic [CW-1:0]    cap_cw;
  logic [CW-1:0]    cap_in;
  logic [CW-1:0]    fill_cw;
  logic             has_room;
  logic             non_empty;
  logic             idx_exists;
  logic [SW+3:0]    idx_ext;
  logic [SW+3:0]    ptr_ext;
  logic [AW-1:0]    base_addr;
  logic [VALUE_BITS+15:0] wval_ext;
  logic [VALUE_BITS+15:0] rval_ext;

  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_PLATES_PER_STACK) ? {27'd0, cap_r} : 32'd0;

  // Capacity: zero acts as one, anything above the built depth acts as the depth.
  assign cap_in = CW'(cap_r);
  always_comb begin
    if (cap_r == 5'd0) begin
      cap_cw = CW'(1);
    end else if (cap_in > DEPTH_CW) begin
      cap_cw = DEPTH_CW;
    end else begin
      cap_cw = cap_in;
    end
  end

  assign fill_cw    = CW'(fill_rd);
  assign has_room   = fill_cw < cap_cw;
  assign non_empty  = fill_rd != '0;
  assign idx_exists = 32'(in_stack_index) < NUM_STACKS;
  assign idx_ext    = {{SW{1'b0}}, in_stack_index};
  assign ptr_ext    = {4'd0, ptr_r};
  assign base_addr  = AW'(ptr_r) * DEPTH_AW;
  assign wval_ext   = {{VALUE_BITS{1'b0}}, val_r};
  assign rval_ext   = {16'd0, plate_rd};

  // Next state and scan pointer.
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    case (state_r)
      ST_CLEAR: begin
        ptr_nxt = ptr_r + SW'(1);
        if (ptr_r == LAST_STACK) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (lfsb_cmd_t'(in_command))
            CMD_PUSH: begin
              ptr_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            CMD_POP_RIGHT: begin
              ptr_nxt   = LAST_STACK;
              state_nxt = ST_SCAN;
            end
            CMD_POP_AT: begin
              if (idx_exists) begin
                ptr_nxt   = idx_ext[SW-1:0];
                state_nxt = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        case (cmd_r)
          CMD_PUSH: begin
            if (has_room || ptr_r == LAST_STACK) begin
              state_nxt = ST_IDLE;
            end else begin
              ptr_nxt = ptr_r + SW'(1);
            end
          end
          CMD_POP_RIGHT: begin
            if (non_empty) begin
              state_nxt = ST_POP;
            end else if (ptr_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              ptr_nxt = ptr_r - SW'(1);
            end
          end
          CMD_POP_AT: begin
            state_nxt = non_empty ? ST_POP : ST_IDLE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_POP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: memory controls and the result to be registered.
  always_comb begin
    res_load   = 1'b0;
    res_status = STS_OK;
    res_pop    = 16'd0;
    res_used   = 4'd0;
    fill_we    = 1'b0;
    fill_wdata = '0;
    plate_we   = 1'b0;
    plate_re   = 1'b0;
    plate_addr = base_addr + AW'(fill_rd);
    case (state_r)
      ST_CLEAR: begin
        fill_we = 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          case (lfsb_cmd_t'(in_command))
            CMD_POP_AT: begin
              if (!idx_exists) begin
                res_load   = 1'b1;
                res_status = STS_EMPTY;
                res_used   = in_stack_index;
              end
            end
            CMD_NONE: begin
              res_load = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        case (cmd_r)
          CMD_PUSH: begin
            if (has_room) begin
              fill_we    = 1'b1;
              fill_wdata = fill_rd + FW'(1);
              plate_we   = 1'b1;
              res_load   = 1'b1;
              res_used   = ptr_ext[3:0];
            end else if (ptr_r == LAST_STACK) begin
              res_load   = 1'b1;
              res_status = STS_FULL;
            end
          end
          CMD_POP_RIGHT, CMD_POP_AT: begin
            if (non_empty) begin
              fill_we    = 1'b1;
              fill_wdata = fill_rd - FW'(1);
              plate_re   = 1'b1;
              plate_addr = base_addr + AW'(fill_rd - FW'(1));
            end else if (cmd_r == CMD_POP_AT) begin
              res_load   = 1'b1;
              res_status = STS_EMPTY;
              res_used   = idx_r;
            end else if (ptr_r == '0) begin
              res_load   = 1'b1;
              res_status = STS_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end
      ST_POP: begin
        res_load = 1'b1;
        res_pop  = rval_ext[15:0];
        res_used = ptr_ext[3:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      cap_r       <= PLATES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= res_load;
      if (cfg_write && paddr[2] == REG_PLATES_PER_STACK) begin
        cap_r <= pwdata[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= lfsb_cmd_t'(in_command);
      val_r <= in_push_value;
      idx_r <= in_stack_index;
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_pop_r    <= res_pop;
      out_used_r   <= res_used;
    end
  end

  // Fill counts: the read address follows the pointer's next value, so the count of
  // the stack under the pointer is ready in every scan cycle.
  lfsb_ram #(
    .WIDTH (FW),
    .DEPTH (NUM_STACKS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (ptr_r),
    .wdata (fill_wdata),
    .re    (1'b1),
    .raddr (ptr_nxt),
    .rdata (fill_rd)
  );

  lfsb_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (NUM_STACKS * STACK_DEPTH)
  ) u_plate_ram (
    .clk   (clk),
    .we    (plate_we),
    .waddr (plate_addr),
    .wdata (wval_ext[VALUE_BITS-1:0]),
    .re    (plate_re),
    .raddr (plate_addr),
    .rdata (plate_rd)
  );

  assign busy             = state_r != ST_IDLE;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_pop_r;
  assign out_used_stack   = out_used_r;

endmodule
`default_nettype wire

@@ rtl/lfsb_ram.sv @@
`default_nettype none
module lfsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

@@ bench/leftmost_fill_stack_bank_tb.sv @@
`timescale 1ns / 1ps
module leftmost_fill_stack_bank_tb;
  import lfsb_pkg::*;

  localparam int STACKS        = 16;
  localparam int DEPTH         = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    lfsb_status_t status;
    logic [15:0]  popped;
    logic [3:0]   used;
  } plate_outcome_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [15:0] in_push_value;
  logic [3:0]  in_stack_index;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_popped_value;
  logic [3:0]  out_used_stack;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  plate_outcome_t awaited_outcomes[$];
  logic [15:0]    shadow_plates [STACKS][DEPTH];
  logic [4:0]     shadow_fill [STACKS];
  logic [4:0]     shadow_capacity;
  int             mismatch_count = 0;
  int             idle_pct = 0;
  int             stall_cycles = 0;
  bit             fill_mode = 1'b1;
  int             mode_items = 0;
  int             mode_limit = 100;

  leftmost_fill_stack_bank u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_push_value    (in_push_value),
    .in_stack_index   (in_stack_index),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_used_stack   (out_used_stack),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A register value of zero behaves as one, anything above the depth as the depth.
  function automatic int effective_capacity();
    int cap;
    cap = shadow_capacity;
    if (cap < 1) cap = 1;
    if (cap > DEPTH) cap = DEPTH;
    return cap;
  endfunction

  function automatic plate_outcome_t apply_plate_command(lfsb_cmd_t cmd, logic [15:0] val,
                                                         logic [3:0] idx);
    plate_outcome_t res;
    int cap;
    int sel;
    res.status = STS_OK;
    res.popped = '0;
    res.used   = '0;
    cap = effective_capacity();
    sel = -1;
    case (cmd)
      CMD_PUSH: begin
        for (int s = STACKS - 1; s >= 0; s--) begin
          if (shadow_fill[s] < cap) sel = s;
        end
        if (sel < 0) begin
          res.status = STS_FULL;
        end else begin
          shadow_plates[sel][shadow_fill[sel]] = val;
          shadow_fill[sel]++;
          res.used = 4'(sel);
        end
      end
      CMD_POP_RIGHT: begin
        for (int s = 0; s < STACKS; s++) begin
          if (shadow_fill[s] != 0) sel = s;
        end
        if (sel < 0) begin
          res.status = STS_EMPTY;
        end else begin
          shadow_fill[sel]--;
          res.popped = shadow_plates[sel][shadow_fill[sel]];
          res.used   = 4'(sel);
        end
      end
      CMD_POP_AT: begin
        res.used = idx;
        if (shadow_fill[idx] != 0) begin
          shadow_fill[idx]--;
          res.popped = shadow_plates[idx][shadow_fill[idx]];
        end else begin
          res.status = STS_EMPTY;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Busy only moves on a rising edge, so its value at the falling edge decides the transfer.
  task automatic send_command(lfsb_cmd_t cmd, logic [15:0] val, logic [3:0] idx);
    plate_outcome_t next_outcome;
    @(negedge clk);
    start          <= 1'b1;
    in_command     <= cmd;
    in_push_value  <= val;
    in_stack_index <= idx;
    while (busy) @(negedge clk);
    @(posedge clk);
    next_outcome = apply_plate_command(cmd, val, idx);
    awaited_outcomes.insert(awaited_outcomes.size(), next_outcome);
  endtask

  task automatic sender_gap();
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    wait (awaited_outcomes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    while (!pready) @(negedge clk);
    @(posedge clk);
    if (addr[2] == REG_PLATES_PER_STACK) shadow_capacity = data[4:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_empty_stacks();
    send_command(CMD_POP_RIGHT, 16'h0000, 4'd0);
    send_command(CMD_POP_AT, 16'hFFFF, 4'd15);
    send_command(CMD_NONE, 16'hFFFF, 4'd15);
    send_command(CMD_PUSH, 16'hFFFF, 4'd0);
    send_command(CMD_PUSH, 16'h0000, 4'd15);
    send_command(CMD_POP_AT, 16'h0000, 4'd0);
  endtask

  // With a capacity of one every stack fills after a single push, so the bank runs out quickly.
  task automatic test_full_bank();
    drain_results();
    write_register(3'd0, 32'h0000_0000);
    for (int n = 0; n < STACKS + 1; n++) begin
      send_command(CMD_PUSH, n[0] ? 16'hAAAA : 16'h5555, 4'(n));
    end
    send_command(CMD_POP_AT, 16'h0000, 4'd9);
    send_command(CMD_PUSH, 16'h1234, 4'd0);
  endtask

  task automatic run_random_items(int count);
    int done;
    int roll;
    int cap;
    int open_stacks;
    int plates;
    lfsb_cmd_t cmd;
    logic [3:0] idx;
    done = 0;
    while (done < count) begin
      cap = effective_capacity();
      open_stacks = 0;
      plates = 0;
      foreach (shadow_fill[s]) begin
        if (shadow_fill[s] < cap) open_stacks++;
        plates += shadow_fill[s];
      end
      // Alternate between filling the bank and emptying it so both ends are reached.
      if ((fill_mode && open_stacks == 0) || (!fill_mode && plates == 0) ||
          mode_items >= mode_limit) begin
        fill_mode  = !fill_mode;
        mode_items = 0;
        mode_limit = $urandom_range(30, 200);
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) cmd = CMD_NONE;
      else if (fill_mode && roll < 80) cmd = CMD_PUSH;
      else if (fill_mode && roll < 90) cmd = CMD_POP_RIGHT;
      else if (fill_mode) cmd = CMD_POP_AT;
      else if (roll < 17) cmd = CMD_PUSH;
      else if (roll < 55) cmd = CMD_POP_RIGHT;
      else cmd = CMD_POP_AT;
      idx = 4'($urandom_range(0, 15));
      if (cmd == CMD_POP_AT && plates != 0 && $urandom_range(0, 1) == 1) begin
        do idx = 4'($urandom_range(0, 15)); while (shadow_fill[idx] == 0);
      end
      sender_gap();
      send_command(cmd, 16'($urandom), idx);
      if (cmd != CMD_NONE) begin
        done++;
        mode_items++;
      end
    end
  endtask

  // Upper bits of the written word are deliberately set in places; only the low five count.
  task automatic test_random_traffic();
    logic [31:0] capacity_words [8] = '{32'h0000_0010, 32'hDEAD_BEE1, 32'h0000_0000,
                                        32'hFFFF_FFFF, 32'h0000_0005, 32'h1234_5682,
                                        32'h0000_0011, 32'hAAAA_AA48};
    int          gap_pcts [8]       = '{0, 85, 26, 0, 85, 26, 0, 85};
    int          item_counts [8]    = '{175, 100, 100, 200, 100, 100, 150, 100};
    for (int p = 0; p < 8; p++) begin
      drain_results();
      idle_pct = 0;
      write_register(3'd0, capacity_words[p]);
      if (p == 4) write_register(3'd4, 32'h0000_0003);
      idle_pct = gap_pcts[p];
      run_random_items(item_counts[p]);
    end
  endtask

  task automatic test_ignored_register();
    drain_results();
    write_register(3'd4, 32'hFFFF_FFE1);
    send_command(CMD_PUSH, 16'h8001, 4'd3);
  endtask

  always @(posedge clk) begin
    plate_outcome_t want;
    if (rst_n && out_valid) begin
      if (awaited_outcomes.size() == 0) begin
        $display("%0t: unexpected result, status %0d popped %h used %0d", $time,
                 out_status, out_popped_value, out_used_stack);
        mismatch_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          mismatch_count++;
        end
        if (out_popped_value !== want.popped) begin
          $display("%0t: popped_value expected %h, got %h", $time, want.popped,
                   out_popped_value);
          mismatch_count++;
        end
        if (out_used_stack !== want.used) begin
          $display("%0t: used_stack expected %0d, got %0d", $time, want.used,
                   out_used_stack);
          mismatch_count++;
        end
      end
    end
  end

  // Any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_command      = '0;
    in_push_value   = '0;
    in_stack_index  = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    shadow_capacity = PLATES_RESET;
    foreach (shadow_fill[s]) shadow_fill[s] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_stacks();
    test_full_bank();
    test_ignored_register();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
